[rtl/slip_frame_decoder_core_assert.svh]
// Assertion macros used by the SLIP decoder datapath.
`ifndef SLIP_FRAME_DECODER_CORE_ASSERT_SVH
`define SLIP_FRAME_DECODER_CORE_ASSERT_SVH

// Implication or plain property checked on every clock edge out of reset.
`define SFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true out of reset.
`define SFD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/sfd_pkg.sv]
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int DEF_BUF_DEPTH = 64;

    localparam logic [7:0] MARK_END = 8'hC0;
    localparam logic [7:0] MARK_ESC = 8'hDB;
    localparam logic [7:0] ESC_END  = 8'hDC;
    localparam logic [7:0] ESC_ESC  = 8'hDD;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_COLLECT,
        ST_ESCAPE,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef enum logic [1:0] {
        WR_RAW,
        WR_END,
        WR_ESC
    } t_wr_sel;

    typedef struct packed {
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    clr;
        logic    rd_en;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic out_free;
        logic rd_last;
    } t_dp_stat;

endpackage

[rtl/sfd_ctrl.sv]
`timescale 1ns / 1ps

module sfd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_rx_byte,
    input  sfd_pkg::t_dp_stat i_stat,
    output logic             o_in_stall,
    output sfd_pkg::t_dp_cmd o_cmd
);
    import sfd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WAIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_WAIT: begin
                if (w_accept && i_rx_byte == MARK_END) begin
                    n_state = ST_COLLECT;
                end
            end
            ST_COLLECT: begin
                if (w_accept) begin
                    if (i_rx_byte == MARK_END) begin
                        n_state = i_stat.count_zero ? ST_WAIT : ST_EMIT_RD;
                    end else if (i_rx_byte == MARK_ESC) begin
                        n_state = ST_ESCAPE;
                    end
                end
            end
            ST_ESCAPE: begin
                if (w_accept) begin
                    if (i_rx_byte == ESC_END || i_rx_byte == ESC_ESC) begin
                        n_state = ST_COLLECT;
                    end else begin
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_EMIT_RD: begin
                if (i_stat.out_free) begin
                    n_state = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                n_state = i_stat.rd_last ? ST_WAIT : ST_EMIT_RD;
            end
            default: n_state = ST_WAIT;
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_stall     = 1'b1;
        o_cmd.wr_en    = 1'b0;
        o_cmd.wr_sel   = WR_RAW;
        o_cmd.clr      = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_WAIT: begin
                o_in_stall = 1'b0;
                if (i_in_valid && i_rx_byte == MARK_END) begin
                    o_cmd.clr = 1'b1;
                end
            end
            ST_COLLECT: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_rx_byte == MARK_END) begin
                        o_cmd.clr = i_stat.count_zero;
                    end else if (i_rx_byte != MARK_ESC) begin
                        o_cmd.wr_en = 1'b1;
                    end
                end
            end
            ST_ESCAPE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_rx_byte == ESC_END) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WR_END;
                    end else if (i_rx_byte == ESC_ESC) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = WR_ESC;
                    end else begin
                        o_cmd.clr = 1'b1;
                    end
                end
            end
            ST_EMIT_RD: begin
                o_cmd.rd_en = i_stat.out_free;
            end
            ST_EMIT_LD: begin
                o_cmd.out_load = 1'b1;
                o_cmd.clr      = i_stat.rd_last;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/sfd_datapath.sv]
`timescale 1ns / 1ps

`include "slip_frame_decoder_core_assert.svh"

module sfd_datapath #(
    parameter int BUF_DEPTH = sfd_pkg::DEF_BUF_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_stall,
    input  sfd_pkg::t_dp_cmd  i_cmd,
    output sfd_pkg::t_dp_stat o_stat,
    output logic              o_out_valid,
    output logic [7:0]        o_data_byte,
    output logic              o_last_byte,
    output logic              o_truncated
);
    import sfd_pkg::*;

    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0]    r_mem [BUF_DEPTH];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [AW-1:0] r_rd_ptr;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_last;
    logic          r_out_trunc;
    logic [7:0]    w_wr_data;
    logic          w_room;

    always_comb begin
        case (i_cmd.wr_sel)
            WR_END:  w_wr_data = MARK_END;
            WR_ESC:  w_wr_data = MARK_ESC;
            default: w_wr_data = i_rx_byte;
        endcase
    end

    assign w_room = (r_count < CW'(BUF_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && w_room) begin
            r_mem[r_count[AW-1:0]] <= w_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_ptr <= '0;
        end else if (i_cmd.clr) begin
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_ptr <= '0;
        end else begin
            if (i_cmd.wr_en) begin
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data  <= r_rd_data;
            r_out_last  <= o_stat.rd_last;
            r_out_trunc <= r_ovf;
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;
    assign o_stat.rd_last    = ((CW'(r_rd_ptr) + CW'(1)) == r_count);

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out_data;
    assign o_last_byte = r_out_last;
    assign o_truncated = r_out_trunc;

    `SFD_NEVER(a_load_over_full, i_clk, i_rst_n, i_cmd.out_load && r_out_valid, "output register overwritten")
    `SFD_ASSERT(a_load_after_read, i_clk, i_rst_n, i_cmd.out_load |-> $past(i_cmd.rd_en), "output load without a preceding read")
    `SFD_NEVER(a_count_range, i_clk, i_rst_n, r_count > CW'(BUF_DEPTH), "byte count beyond buffer depth")

endmodule

[rtl/slip_frame_decoder_core.sv]
`timescale 1ns / 1ps

// SLIP receive decoder. Raw line bytes enter on i_in_valid / i_rx_byte, and a
// request is taken at a clock edge where i_in_valid is high and o_in_stall is
// low. While a frame is being collected one byte is taken every cycle; the
// escaped pairs are resolved on the way into the frame buffer.
// When a closing delimiter arrives after at least one payload byte, the input
// stalls and the buffered frame is read out on o_out_valid / o_data_byte, one
// request per byte, with o_last_byte on the final byte and o_truncated on every
// byte of a frame that overflowed the buffer. Each byte is read through the
// single registered read port of the frame buffer and then loaded into the
// output register before the next byte is read.
// Input is taken again in the cycle after the last byte enters the output
// register. A stall from the receiver holds the output register and pauses
// the readout; while collecting, a waiting result does not hold up the input.
// Synchronous reset puts the decoder into the state that waits for an opening
// delimiter and empties the output register; the buffer contents are not
// cleared.
module slip_frame_decoder_core #(
    parameter int BUF_DEPTH = sfd_pkg::DEF_BUF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_byte,
    output logic       o_last_byte,
    output logic       o_truncated
);
    import sfd_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_stat     (w_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    sfd_datapath #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx_byte),
        .i_out_stall (i_out_stall),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_data_byte (o_data_byte),
        .o_last_byte (o_last_byte),
        .o_truncated (o_truncated)
    );

endmodule

[test/slip_frame_decoder_checker.sv]
`timescale 1ns / 1ps

module slip_frame_decoder_checker #(
    parameter int DEPTH = sfd_pkg::DEF_BUF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_truncated,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_frames
);
    import sfd_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       trunc;
    } t_frame_byte;

    t_state      rx_mode;
    logic [7:0]  frame_buf [64];
    int unsigned held;
    logic        dropped;
    t_frame_byte frame_q [$];
    t_frame_byte want;
    int          fails;
    int          checked;
    int          frames;

    task automatic store_byte(input logic [7:0] b);
        if (held < DEPTH) begin
            frame_buf[held] = b;
            held++;
        end else begin
            dropped = 1'b1;
        end
    endtask

    task automatic close_frame();
        held    = 0;
        dropped = 1'b0;
        rx_mode = ST_WAIT;
    endtask

    // Works out what one accepted line byte does to the frame in progress.
    task automatic decode_rx(input logic [7:0] b);
        t_frame_byte fb;
        case (rx_mode)
            ST_COLLECT: begin
                if (b == MARK_END) begin
                    for (int k = 0; k < held; k++) begin
                        fb.data  = frame_buf[k];
                        fb.last  = (k + 1 == held);
                        fb.trunc = dropped;
                        frame_q.push_back(fb);
                    end
                    if (held != 0) frames++;
                    close_frame();
                end else if (b == MARK_ESC) begin
                    rx_mode = ST_ESCAPE;
                end else begin
                    store_byte(b);
                end
            end
            ST_ESCAPE: begin
                if (b == ESC_END) begin
                    store_byte(MARK_END);
                    rx_mode = ST_COLLECT;
                end else if (b == ESC_ESC) begin
                    store_byte(MARK_ESC);
                    rx_mode = ST_COLLECT;
                end else begin
                    // A broken escape throws the whole frame away.
                    close_frame();
                end
            end
            default: begin
                if (b == MARK_END) begin
                    held    = 0;
                    dropped = 1'b0;
                    rx_mode = ST_COLLECT;
                end else begin
                    rx_mode = ST_WAIT;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            close_frame();
            frame_q.delete();
            fails   = 0;
            checked = 0;
            frames  = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (frame_q.size() == 0) begin
                    $error("unexpected result request: data_byte %0h", i_data_byte);
                    fails++;
                end else begin
                    want = frame_q.pop_front();
                    checked++;
                    if (i_data_byte !== want.data) begin
                        $error("data_byte: expected %0h, got %0h", want.data, i_data_byte);
                        fails++;
                    end
                    if (i_last_byte !== want.last) begin
                        $error("last_byte: expected %0d, got %0d", want.last, i_last_byte);
                        fails++;
                    end
                    if (i_truncated !== want.trunc) begin
                        $error("truncated: expected %0d, got %0d", want.trunc, i_truncated);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) decode_rx(i_rx_byte);
        end
        o_fail_count <= fails;
        o_pending    <= frame_q.size();
        o_checked    <= checked;
        o_frames     <= frames;
    end

endmodule

[test/slip_frame_decoder_core_tb.sv]
`timescale 1ns / 1ps

module slip_frame_decoder_core_tb;
    import sfd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_data_byte;
    logic       o_last_byte;
    logic       o_truncated;

    int chk_fails;
    int chk_pending;
    int chk_checked;
    int chk_frames;
    int n_fed;
    int idle_cycles;
    bit quiet;

    slip_frame_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_byte (o_data_byte),
        .o_last_byte (o_last_byte),
        .o_truncated (o_truncated)
    );

    slip_frame_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_data_byte  (o_data_byte),
        .i_last_byte  (o_last_byte),
        .i_truncated  (o_truncated),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked),
        .o_frames     (chk_frames)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The stall is looked at on the falling clock edge before each rising edge, so the
    // request is known to be taken at the rising edge that follows.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        n_fed++;
    endtask

    // Payload values that collide with the framing bytes go out as escaped pairs.
    task automatic send_payload(input logic [7:0] b);
        if (b == MARK_END) begin
            send_byte(MARK_ESC);
            send_byte(ESC_END);
        end else if (b == MARK_ESC) begin
            send_byte(MARK_ESC);
            send_byte(ESC_ESC);
        end else begin
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] pick_payload();
        int sel;
        sel = $urandom_range(0, 11);
        if (sel < 2) return MARK_END;
        if (sel < 4) return MARK_ESC;
        if (sel == 4) return ESC_END;
        if (sel == 5) return ESC_ESC;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_bad_escape();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) b = MARK_END;
        while (b == ESC_END || b == ESC_ESC) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // A broken frame ends in a bad escape somewhere in place of its closing delimiter.
    task automatic send_frame(input int len, input bit broken);
        int cut;
        cut = broken ? $urandom_range(0, len) : -1;
        send_byte(MARK_END);
        for (int k = 0; k < len; k++) begin
            if (k == cut) break;
            send_payload(pick_payload());
        end
        if (broken) begin
            send_byte(MARK_ESC);
            send_byte(pick_bad_escape());
        end else begin
            send_byte(MARK_END);
        end
    endtask

    initial begin
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int len;
        n_fed       = 0;
        quiet       = 1'b0;
        idle_cycles <= 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_rx_byte   <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Line noise before any frame is ignored.
        send_byte(8'h00); send_byte(8'hFF); send_byte(MARK_ESC);
        send_byte(ESC_END); send_byte(ESC_ESC);
        // Empty frame, then the byte extremes.
        send_byte(MARK_END); send_byte(MARK_END);
        send_byte(MARK_END); send_byte(8'h00); send_byte(8'hFF); send_byte(MARK_END);
        // Both escaped pairs.
        send_byte(MARK_END); send_byte(MARK_ESC); send_byte(ESC_END);
        send_byte(MARK_ESC); send_byte(ESC_ESC); send_byte(MARK_END);
        // Bad escapes, one of them with a delimiter after the escape byte.
        send_byte(MARK_END); send_byte(8'h11); send_byte(MARK_ESC); send_byte(8'h7E);
        send_byte(8'h22);
        send_byte(MARK_END); send_byte(MARK_ESC); send_byte(MARK_END);
        // An ordinary frame must still open with its own delimiter.
        send_byte(MARK_END); send_byte(8'hA5); send_byte(MARK_END);

        // A frame that exactly fills the buffer and one that spills over it.
        send_frame(DEF_BUF_DEPTH, 1'b0);
        send_frame(DEF_BUF_DEPTH + $urandom_range(1, 6), 1'b0);

        while (n_fed < 230) begin
            if (n_fed >= 200) quiet = 1'b1;
            if ($urandom_range(0, 4) == 0) send_byte(pick_bad_escape() & 8'h7F);
            case ($urandom_range(0, 11))
                0:       len = 0;
                1:       len = $urandom_range(9, 16);
                default: len = $urandom_range(1, 8);
            endcase
            send_frame(len, $urandom_range(0, 5) == 0);
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (chk_pending != 0);
        repeat (16) @(posedge i_clk);

        $display("Fed %0d line bytes; %0d frames decoded and %0d payload requests checked.",
                 n_fed, chk_frames, chk_checked);
        $display("Covered empty, escaped, broken, full and overflowing frames under stalls.");
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
